FILE: sv/assert_macros.svh
// Assertion helper macros shared by the RTL of the timed entry table.
// No dependencies; files that assert pull this in with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// Antecedent in one cycle forces the consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Antecedent forces the consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`endif

FILE: sv/tei_pkg.sv
// Package for the timed entry table: sizes, flag bits, word and entry types.
// No dependencies; imported by tei_table and timed_entry_insert_or_update.
package tei_pkg;

   localparam int TABLE_DEPTH   = 20;
   localparam int DURATION_BITS = 32;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   localparam int TYPE_W  = 3;
   localparam int KEY_W   = 16;
   localparam int FLAGS_W = 8;
   localparam int DUR_W   = 32;
   localparam int SLOT_W  = 5;

   localparam int FLAG_ADD_BIT      = 7;  // 0x80
   localparam int FLAG_NOSEARCH_BIT = 6;  // 0x40

   typedef logic [DURATION_BITS-1:0] dur_type;
   typedef logic [DURATION_BITS:0]   dur_sum_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  item_type;
      logic [KEY_W-1:0]   item_key;
      logic [FLAGS_W-1:0] item_flags;
      logic [DUR_W-1:0]   item_duration;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [SLOT_W-1:0] slot_index;
      logic              hit_existing;
      logic [DUR_W-1:0]  duration_now;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  slot_type;
      logic [KEY_W-1:0]   slot_key;
      logic [FLAGS_W-1:0] slot_flags;
      dur_type            slot_duration;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } tbl_wr_type;

endpackage

FILE: sv/tei_table.sv
// Entry storage of the timed entry table: one write port, one registered read.
// Depends on tei_pkg for the entry and write-port types.
module tei_table
   import tei_pkg::*;
(
   input  logic       clock,
   input  tbl_wr_type wr,
   input  addr_type   rd_addr,
   output entry_type  rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/timed_entry_insert_or_update.sv
// Top level of the timed entry table: request sequencer, search and update.
// Depends on tei_pkg, tei_table and assert_macros.svh.
//
// Keeps up to TABLE_DEPTH timed entries (type, key, flags, duration). A request
// word is taken when start is high and busy is low; busy then stays high until
// the response has been produced. The search walks the used entries one per
// cycle through the single read port of the table memory, comparing type and
// key in one shared comparator. With no match the search runs past every used
// entry and then appends if there is room; when an entry matches, an extra
// update state does the saturating add or the replace and the write-back;
// when the search is skipped (flag bit 7 clear, bit 6 set) it appends directly. The
// response is shown on rsp_data for exactly one cycle with rsp_valid high; the
// receiver cannot stall it, so it must take the word in that cycle. A new
// request may be started in the same cycle the response is shown. The table
// starts empty after reset; no clearing pass is needed since only entries
// below the fill count are ever compared.
`include "assert_macros.svh"

module timed_entry_insert_or_update
   import tei_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    idx_ff, idx_in;     // entry whose data sits on the read port
   cnt_type    used_ff, used_in;   // fill count
   req_type    req_ff, req_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   tbl_wr_type  wr;
   addr_type    rd_addr;
   entry_type   rd_data;

   dur_type     req_dur;
   dur_sum_type dur_sum;
   dur_type     dur_new;
   logic        search_on;
   logic        hit;
   logic        at_end;
   logic        full;

   tei_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request duration kept at the table's duration width.
   assign req_dur   = dur_type'(req_ff.item_duration);
   assign search_on = req_ff.item_flags[FLAG_ADD_BIT] | ~req_ff.item_flags[FLAG_NOSEARCH_BIT];
   assign hit       = (rd_data.slot_type == req_ff.item_type) &&
                      (rd_data.slot_key == req_ff.item_key);
   assign at_end    = (idx_ff == used_ff);
   assign full      = (used_ff == cnt_type'(TABLE_DEPTH));

   // Shared adder: saturating sum of stored and requested duration.
   assign dur_sum = {1'b0, rd_data.slot_duration} + {1'b0, req_dur};
   assign dur_new = req_ff.item_flags[FLAG_ADD_BIT] ?
                    (dur_sum[DURATION_BITS] ? '1 : dur_sum[DURATION_BITS-1:0]) : req_dur;

   // Read address follows the next index so data lines up with idx_ff.
   assign rd_addr = (idx_in < cnt_type'(TABLE_DEPTH)) ? idx_in[ADDR_W-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr.en        = 1'b0;
      wr.addr      = used_ff[ADDR_W-1:0];
      wr.data.slot_type     = req_ff.item_type;
      wr.data.slot_key      = req_ff.item_key;
      wr.data.slot_flags    = req_ff.item_flags;
      wr.data.slot_duration = req_dur;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!search_on || at_end) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (full) begin
                  // refused: all fields zero
                  rsp_in = '0;
               end else begin
                  wr.en               = 1'b1;
                  used_in             = used_ff + cnt_type'(1);
                  rsp_in.accepted     = 1'b1;
                  rsp_in.slot_index   = SLOT_W'(used_ff);
                  rsp_in.hit_existing = 1'b0;
                  rsp_in.duration_now = DUR_W'(req_dur);
               end
            end else if (hit) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + cnt_type'(1);
            end
         end
         ST_UPDATE: begin
            // read data still holds entry idx_ff
            wr.en                 = 1'b1;
            wr.addr               = idx_ff[ADDR_W-1:0];
            wr.data               = rd_data;
            wr.data.slot_duration = dur_new;
            rsp_valid_in          = 1'b1;
            rsp_in.accepted       = 1'b1;
            rsp_in.slot_index     = SLOT_W'(idx_ff);
            rsp_in.hit_existing   = 1'b1;
            rsp_in.duration_now   = DUR_W'(dur_new);
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= cnt_type'(TABLE_DEPTH))
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `ASSERT_NEXT(a_write_ends, clock, reset, wr.en, !busy && rsp_valid)
   `ASSERT_SAME(a_hit_ok, clock, reset, rsp_valid && rsp_data.hit_existing, rsp_data.accepted)
   `ASSERT_SAME(a_refuse_zero, clock, reset, rsp_valid && !rsp_data.accepted,
                rsp_data.slot_index == '0 && rsp_data.duration_now == '0)

endmodule

FILE: tb/timed_entry_insert_or_update_test.sv
// Self-checking bench for timed_entry_insert_or_update: insert, update and refusal paths.
// Depends on tei_pkg and the RTL; words come from a queue, and results are predicted
// from a private copy of the entry table.
module timed_entry_insert_or_update_test;
   import tei_pkg::*;

   localparam int RANDOM_WORDS = 1550;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 40;     // idle clocks run after the last result before the report

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Request words still to be driven, and outcomes still to be seen on rsp_data.
   req_type word_q[$];
   rsp_type outcome_q[$];

   int words_sent;       // words put on req_data (driver, falling edge)
   int words_taken;      // words accepted by the block (monitor, rising edge)
   int directed_words;
   int errors;
   int cycle_count;

   // Private copy of the entry table. Flags are stored by the block but never read
   // back, so only type, key and duration are kept here.
   logic [TYPE_W-1:0] tbl_type [TABLE_DEPTH];
   logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
   dur_type           tbl_dur  [TABLE_DEPTH];
   int                tbl_used;

   timed_entry_insert_or_update u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one accepted word to the table copy and returns the outcome it produces.
   function automatic rsp_type apply_request(req_type w);
      rsp_type     r;
      dur_type     d;
      dur_sum_type s;
      r = '0;
      d = dur_type'(w.item_duration);
      // Search runs on add, or on replace unless the no-search bit is set.
      if (w.item_flags[FLAG_ADD_BIT] || !w.item_flags[FLAG_NOSEARCH_BIT]) begin
         for (int i = 0; i < tbl_used; i++) begin
            if (tbl_type[i] == w.item_type && tbl_key[i] == w.item_key) begin
               if (w.item_flags[FLAG_ADD_BIT]) begin
                  s = {1'b0, tbl_dur[i]} + d;
                  // saturate on carry out
                  tbl_dur[i] = s[DURATION_BITS] ? '1 : s[DURATION_BITS-1:0];
               end else begin
                  tbl_dur[i] = d;
               end
               r.accepted     = 1'b1;
               r.slot_index   = SLOT_W'(i);
               r.hit_existing = 1'b1;
               r.duration_now = DUR_W'(tbl_dur[i]);
               return r;
            end
         end
      end
      // No hit: append if there is room, else refuse with all fields zero.
      if (tbl_used < TABLE_DEPTH) begin
         tbl_type[tbl_used] = w.item_type;
         tbl_key[tbl_used]  = w.item_key;
         tbl_dur[tbl_used]  = d;
         r.accepted         = 1'b1;
         r.slot_index       = SLOT_W'(tbl_used);
         r.duration_now     = DUR_W'(d);
         tbl_used++;
      end
      return r;
   endfunction

   // Only the first ten failures are printed; the rest are only counted.
   task automatic note_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic queue_word(logic [TYPE_W-1:0] t, logic [KEY_W-1:0] k,
                             logic [FLAGS_W-1:0] f, logic [DUR_W-1:0] d);
      req_type w;
      w.item_type     = t;
      w.item_key      = k;
      w.item_flags    = f;
      w.item_duration = d;
      word_q.push_back(w);
   endtask

   function automatic bit all_settled();
      return word_q.size() == 0 && words_taken == words_sent && outcome_q.size() == 0;
   endfunction

   // Driver: changes inputs on the falling edge. A new word goes out only once the
   // previous one was taken. The sender idles 19% of the time in the first third of
   // the run, 51% in the second, and never in the last.
   always @(negedge clock) begin
      int idle_pct;
      if (!reset && words_taken == words_sent) begin
         if (words_sent * 3 < directed_words + RANDOM_WORDS) begin
            idle_pct = 19;
         end else if (words_sent * 3 < 2 * (directed_words + RANDOM_WORDS)) begin
            idle_pct = 51;
         end else begin
            idle_pct = 0;
         end
         if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_data <= word_q.pop_front();
            start    <= 1'b1;
            words_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: samples on the rising edge. The result is checked before the word
   // accepted at the same edge is predicted, since a new request may start in the
   // very cycle the previous result is shown.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               note_error($sformatf("result with nothing expected: ok=%0d idx=%0d hit=%0d dur=%h",
                                    rsp_data.accepted, rsp_data.slot_index,
                                    rsp_data.hit_existing, rsp_data.duration_now));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.accepted !== want.accepted ||
                   rsp_data.slot_index !== want.slot_index ||
                   rsp_data.hit_existing !== want.hit_existing ||
                   rsp_data.duration_now !== want.duration_now) begin
                  note_error($sformatf({"mismatch: expected ok=%0d idx=%0d hit=%0d dur=%h,",
                                        " got ok=%0d idx=%0d hit=%0d dur=%h"},
                                       want.accepted, want.slot_index, want.hit_existing,
                                       want.duration_now, rsp_data.accepted,
                                       rsp_data.slot_index, rsp_data.hit_existing,
                                       rsp_data.duration_now));
               end
            end
         end
         if (start && !busy) begin
            outcome_q.push_back(apply_request(req_data));
            words_taken++;
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus: directed words first, then random ones, then drain and report.
   initial begin
      logic [TYPE_W-1:0]  t;
      logic [KEY_W-1:0]   k;
      logic [FLAGS_W-1:0] f;
      logic [DUR_W-1:0]   d;
      logic [TYPE_W-1:0]  last_type;
      logic [KEY_W-1:0]   last_key;
      int                 pick;

      // Extremes, every operation, saturation, skipped search, type-only mismatch.
      queue_word(3'd0, 16'h0000, 8'h00, 32'h0000_0000);  // append slot 0
      queue_word(3'd7, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);  // add, miss, append slot 1
      queue_word(3'd7, 16'hFFFF, 8'h80, 32'h0000_0001);  // add hit, saturates
      queue_word(3'd0, 16'h0000, 8'h3F, 32'h1234_5678);  // replace slot 0
      queue_word(3'd0, 16'h0000, 8'h40, 32'h0000_0005);  // search skipped: duplicate appended
      queue_word(3'd0, 16'h0000, 8'h80, 32'hFFFF_FFF0);  // add hit on first copy, overflow
      queue_word(3'd3, 16'h8000, 8'hC0, 32'h8000_0000);  // add, miss, append
      queue_word(3'd3, 16'h8000, 8'hC0, 32'h7FFF_FFFF);  // add hit, lands on all-ones exactly
      queue_word(3'd4, 16'h8000, 8'h80, 32'h0000_0001);  // same key, other type: append
      queue_word(3'd3, 16'h7FFF, 8'h00, 32'hAAAA_AAAA);  // same type, other key: append
      // Fill the rest of the table with skipped-search appends.
      for (int i = 6; i < TABLE_DEPTH; i++) begin
         t = TYPE_W'(i);
         k = KEY_W'($urandom);
         queue_word(t, k, 8'h40 | FLAGS_W'($urandom_range(0, 63)), DUR_W'($urandom));
         last_type = t;
         last_key  = k;
      end
      // Table full: a miss and a skipped search are refused, a hit still updates.
      queue_word(3'd5, 16'h5555, 8'h80, 32'h0000_0010);
      queue_word(last_type, last_key, 8'h40, 32'h0000_0020);
      queue_word(last_type, last_key, 8'h00, 32'h5555_5555);
      directed_words = word_q.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hold off until every directed result is back; the table is full from here
      // on, so random words are drawn against its now fixed types and keys.
      do @(negedge clock); while (!all_settled());
      @(posedge clock);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 99) < 75) begin
            pick = $urandom_range(0, TABLE_DEPTH - 1);
            t    = tbl_type[pick];
            k    = tbl_key[pick];
         end else begin
            t = TYPE_W'($urandom);
            k = KEY_W'($urandom);
         end
         f    = FLAGS_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            f[FLAG_ADD_BIT] = 1'b1;
         end else if (pick < 75) begin
            f[FLAG_ADD_BIT]      = 1'b0;
            f[FLAG_NOSEARCH_BIT] = 1'b0;
         end else begin
            f[FLAG_ADD_BIT]      = 1'b0;
            f[FLAG_NOSEARCH_BIT] = 1'b1;
         end
         case ($urandom_range(0, 3))
            0: begin
               d = $urandom;
            end
            1: begin
               d = DUR_W'($urandom_range(0, 255));
            end
            2: begin
               d = '1 - DUR_W'($urandom_range(0, 255));
            end
            default: begin
               d = $urandom >> $urandom_range(0, 31);
            end
         endcase
         queue_word(t, k, f, d);
      end

      do @(negedge clock); while (!all_settled());
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += outcome_q.size();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: timed_entry_insert_or_update.f
+incdir+sv
sv/tei_pkg.sv
sv/tei_table.sv
sv/timed_entry_insert_or_update.sv
tb/timed_entry_insert_or_update_test.sv
